@@ hdl/sha_bc_pkg.sv @@
package sha_bc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLK_WDS  = 16;
    localparam int unsigned HASH_WDS = 8;
    localparam int unsigned ROUNDS   = 64;

    localparam int unsigned WC_W  = $clog2(BLK_WDS);
    localparam int unsigned RC_W  = $clog2(ROUNDS);
    localparam int unsigned DCW   = $clog2(HASH_WDS + 1);

    localparam logic [DCW-1:0] DIG_CNT_256 = DCW'(HASH_WDS);
    localparam logic [DCW-1:0] DIG_CNT_224 = DCW'(HASH_WDS - 1);

    localparam logic MODE_SHA256 = 1'b0;
    localparam logic MODE_SHA224 = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word C_ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam t_word C_IV_256 [HASH_WDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word C_IV_224 [HASH_WDS] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    // controller -> datapath
    typedef struct packed {
        logic            shift_in;
        logic            load_iv;
        logic            load_work;
        logic            round;
        logic [RC_W-1:0] round_idx;
        logic            add;
        logic            emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dig_busy;
    } t_sts;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ hdl/sha256_block_compressor.sv @@
// Timing: after the transfer of a block's 16th word, 64 rounds run, then the add step
//   loads the chaining state and, for a final block, the output register; digest words
//   then follow one per cycle while m_axis_tready is high. Words are taken one per cycle
//   while gathering, but none while the single round unit does one round a cycle for a
//   block; the add step holds while an earlier digest is still draining.
// Reset (synchronous, i_rst_n low): chaining state to SHA-256 initial values, mode SHA-256,
//   word count zero, output empty.
module sha256_block_compressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,   // digest_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] msg_word
    input  logic [1:0]  s_axis_tuser,    // [0] start_message, [1] final_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] digest_word
    output logic        m_axis_tlast     // digest_last
);
    import sha_bc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha_bc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_start (s_axis_tuser[0]),
        .i_in_final (s_axis_tuser[1]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sha_bc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_word        (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_word    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

@@ hdl/sha_bc_ctrl.sv @@
module sha_bc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_start,
    input  logic              i_in_final,
    output logic              o_in_ready,
    input  sha_bc_pkg::t_sts  i_sts,
    output sha_bc_pkg::t_cmd  o_cmd
);
    import sha_bc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [WC_W-1:0] r_wc, n_wc;
    logic [RC_W-1:0] r_rc, n_rc;
    logic            r_final, n_final;

    logic            acc;
    logic [WC_W-1:0] wc_eff;
    logic            compress;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    // a start word opens a fresh block and drops any partial one
    assign wc_eff     = i_in_start ? '0 : r_wc;
    assign compress   = acc && (wc_eff == WC_W'(BLK_WDS - 1));

    always_comb begin
        n_state = r_state;
        n_wc    = r_wc;
        n_rc    = r_rc;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.round_idx = r_rc;
        case (r_state)
            ST_IDLE: begin
                o_cmd.shift_in  = acc;
                o_cmd.load_iv   = acc && i_in_start;
                o_cmd.load_work = compress;
                if (acc) begin
                    n_wc = wc_eff + 1'b1;
                end
                if (compress) begin
                    n_wc    = '0;
                    n_rc    = '0;
                    n_final = i_in_final;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rc = r_rc + 1'b1;
                if (r_rc == RC_W'(ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                // hold until the previous digest has drained
                if (!i_sts.dig_busy) begin
                    o_cmd.add  = 1'b1;
                    o_cmd.emit = r_final;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wc    <= '0;
            r_rc    <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wc    <= n_wc;
            r_rc    <= n_rc;
            r_final <= n_final;
        end
    end

    a_add_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add |-> !i_sts.dig_busy)
        else $error("compression result added while digest still draining");

    a_last_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rc == RC_W'(ROUNDS - 1)) |=> (r_state == ST_ADD))
        else $error("round sequence did not end in the add step");

    a_block_starts_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        compress |=> (r_state == ST_ROUND && r_rc == '0 && r_wc == '0))
        else $error("full block did not start compression");

    a_start_no_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_start) |-> !o_cmd.load_work)
        else $error("start word triggered a compression");

endmodule

@@ hdl/sha_bc_dp.sv @@
module sha_bc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  sha_bc_pkg::t_word   i_word,
    input  sha_bc_pkg::t_cmd    i_cmd,
    output sha_bc_pkg::t_sts    o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sha_bc_pkg::t_word   o_out_word,
    output logic                o_out_last
);
    import sha_bc_pkg::*;

    t_word r_w     [BLK_WDS];
    t_word r_wv    [HASH_WDS];
    t_word r_chain [HASH_WDS];
    t_word r_dig   [HASH_WDS];
    logic [DCW-1:0] r_dig_cnt;
    logic           r_mode;

    t_word w_next;
    t_word t1, t2;
    t_word ch, maj;
    t_word sum   [HASH_WDS];
    logic  out_acc;

    // rolling schedule window: r_w[0] is the word for the current round
    assign w_next = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];

    assign ch  = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
    assign maj = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
    assign t1  = r_wv[7] + bsig1(r_wv[4]) + ch + C_ROUND_K[i_cmd.round_idx] + r_w[0];
    assign t2  = bsig0(r_wv[0]) + maj;

    always_comb begin
        for (int i = 0; i < HASH_WDS; i++) begin
            sum[i] = r_chain[i] + r_wv[i];
        end
    end

    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_valid = (r_dig_cnt != '0);
    assign o_out_word  = r_dig[0];
    assign o_out_last  = (r_dig_cnt == DCW'(1));

    assign o_sts.dig_busy = o_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in || i_cmd.round) begin
            for (int i = 0; i < BLK_WDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLK_WDS-1] <= i_cmd.round ? w_next : i_word;
        end

        if (i_cmd.load_work) begin
            r_wv <= r_chain;
        end else if (i_cmd.round) begin
            r_wv[0] <= t1 + t2;
            r_wv[1] <= r_wv[0];
            r_wv[2] <= r_wv[1];
            r_wv[3] <= r_wv[2];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[5] <= r_wv[4];
            r_wv[6] <= r_wv[5];
            r_wv[7] <= r_wv[6];
        end

        if (i_cmd.emit) begin
            r_dig <= sum;
        end else if (out_acc) begin
            for (int i = 0; i < HASH_WDS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SHA256;
            r_chain   <= C_IV_256;
            r_dig_cnt <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.load_iv) begin
                r_chain <= (r_mode == MODE_SHA224) ? C_IV_224 : C_IV_256;
            end else if (i_cmd.add) begin
                r_chain <= sum;
            end
            if (i_cmd.emit) begin
                r_dig_cnt <= (r_mode == MODE_SHA224) ? DIG_CNT_224 : DIG_CNT_256;
            end else if (out_acc) begin
                r_dig_cnt <= r_dig_cnt - 1'b1;
            end
        end
    end

    a_dig_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig_cnt <= DCW'(HASH_WDS))
        else $error("digest count out of range");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_dig_cnt == DIG_CNT_256 || r_dig_cnt == DIG_CNT_224))
        else $error("digest emitted with wrong word count");

    a_emit_matches_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_dig[0] == r_chain[0]))
        else $error("first digest word differs from chaining state");

endmodule

@@ sim/tb_sha256_block_compressor.sv @@
`timescale 1ns / 100ps

module tb_sha256_block_compressor;

    import sha_bc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 100;   // covers one compression plus output
    localparam int unsigned LONG_HOLD     = 600;
    localparam int unsigned PHASE_WORDS   = 80;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] INIT_256 [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] INIT_224 [8] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_beat;

    class sha_digest_tracker;
        logic [31:0]  chain [8];
        logic [31:0]  blk [16];
        int unsigned  fill;
        logic         mode;
        t_digest_beat expected_digest_q [$];
        int unsigned  mismatches;

        function new();
            mode       = MODE_SHA256;
            chain      = INIT_256;
            fill       = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] ror32(logic [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < 64; i++) begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            v = chain;
            for (int i = 0; i < 64; i++) begin
                s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
                t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
                s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
                t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        // Note one accepted message word and queue any digest words it causes.
        function void take_word(logic [31:0] word, logic start, logic final_blk);
            int unsigned n;
            if (start) begin
                chain = (mode == MODE_SHA224) ? INIT_224 : INIT_256;
                fill  = 0;
            end
            blk[fill] = word;
            if (fill != 15) begin
                fill++;
                return;
            end
            fill = 0;
            compress();
            if (!final_blk) return;
            n = (mode == MODE_SHA224) ? 7 : 8;
            for (int i = 0; i < n; i++)
                expected_digest_q.push_back('{word: chain[i], last: (i == n - 1)});
        endfunction

        function int unsigned pending();
            return expected_digest_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_word(logic [31:0] word, logic last);
            t_digest_beat exp_beat;
            if (expected_digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %h last %b", word, last));
                return;
            end
            exp_beat = expected_digest_q.pop_front();
            if (word !== exp_beat.word)
                report_mismatch($sformatf("digest word %h, expected %h", word, exp_beat.word));
            if (last !== exp_beat.last)
                report_mismatch($sformatf("tlast %b, expected %b", last, exp_beat.last));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] msg_word
    logic [1:0]  s_axis_tuser  = '0;   // [0] start_message, [1] final_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest_word
    logic        m_axis_tlast;

    sha_digest_tracker digests;
    int unsigned       words_sent   = 0;
    int unsigned       cycle_cnt    = 0;
    bit                src_idle_en  = 1'b1;
    bit                sink_idle_en = 1'b1;
    bit                hold_req     = 1'b0;

    sha256_block_compressor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_sha256_block_compressor failed");
            $finish;
        end
    end

    // Receiver: random back-pressure bursts, plus one long hold on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            digests.check_word(m_axis_tdata, m_axis_tlast);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] word, input logic start, input logic final_blk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {final_blk, start};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        digests.take_word(word, start, final_blk);
        words_sent++;
    endtask

    // Mostly whole messages of 1 to 3 blocks; some continue the previous chain,
    // some never finish, some are cut off mid-block.
    task automatic send_message();
        int unsigned kind, nblk, nw;
        bit          with_start, with_final;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            nw = $urandom_range(1, 15);
            for (int i = 0; i < nw; i++)
                send_word(rand_word(), (i == 0) && $urandom_range(0, 1), $urandom_range(0, 1));
            return;
        end
        nblk       = $urandom_range(1, 3);
        with_start = (kind != 1);
        with_final = (kind != 2);
        for (int b = 0; b < nblk; b++) begin
            for (int i = 0; i < 16; i++) begin
                send_word(rand_word(),
                          with_start && b == 0 && i == 0,
                          (i == 15) ? (with_final && b == nblk - 1)
                                    : ($urandom_range(0, 15) == 0));
            end
        end
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (digests.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        digests.mode = mode;
    endtask

    initial begin
        int unsigned phase_end;
        digests = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset mode: a stray final flag mid-block, then a restart
        // mid-block followed by a full block of all-zero and all-one words.
        send_word('1, 1'b1, 1'b0);
        send_word('0, 1'b0, 1'b1);
        send_word('1, 1'b0, 1'b0);
        for (int i = 0; i < 16; i++)
            send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0, i == 5 || i == 15);

        for (int ph = 1; ph <= 4; ph++) begin
            wait_until_idle();
            write_mode(ph[0] ? MODE_SHA224 : MODE_SHA256);
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == 4) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) send_message();
        end

        wait_until_idle();
        if (digests.mismatches == 0) begin
            $display("tb_sha256_block_compressor passed");
        end else begin
            $display("tb_sha256_block_compressor failed");
        end
        $finish;
    end

endmodule
